>>> sv/owbm_pkg.sv
// ----------------------------------------------------------------------------
// owbm_pkg: shared definitions for the 1-Wire bus master
// Phase and command codes, register indexes, reset values and the result
// word layout.
// ----------------------------------------------------------------------------
package owbm_pkg;

  localparam int TickW = 10;
  localparam int CfgW  = 10;
  localparam int CfgIdxW = 2;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_RESET = 2'd1;
  localparam logic [1:0] PH_WRITE = 2'd2;
  localparam logic [1:0] PH_READ  = 2'd3;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_RESET = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  localparam logic [CfgIdxW-1:0] CFG_RESET_LOW     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRESENCE_WAIT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SLOT          = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SAMPLE_DELAY  = 2'd3;

  localparam logic [9:0] RESET_LOW_DEF     = 10'd485;
  localparam logic [7:0] PRESENCE_WAIT_DEF = 8'd30;
  localparam logic [7:0] SLOT_DEF          = 8'd60;
  localparam logic [7:0] SAMPLE_DELAY_DEF  = 8'd10;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] rx_byte;
    logic       rejected;
  } res_t;

endpackage

>>> sv/owbm_if.sv
// ----------------------------------------------------------------------------
// owbm_cmd_if / owbm_res_if: channels of the 1-Wire bus master
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface owbm_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] tx_byte;
  logic       line_level;

  modport source (output valid, output kind, output tx_byte, output line_level, input ready);
  modport sink (input valid, input kind, input tx_byte, input line_level, output ready);
endinterface

interface owbm_res_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic       presence;
  logic [7:0] rx_byte;
  logic       rejected;

  modport source (output valid, output drive_low, output busy_res, output done_res,
                  output presence, output rx_byte, output rejected, input ready);
  modport sink (input valid, input drive_low, input busy_res, input done_res,
                input presence, input rx_byte, input rejected, output ready);
endinterface

>>> sv/owbm_core.sv
// ----------------------------------------------------------------------------
// owbm_core: bus master state and slot timing
// Holds the timing registers and the operation state, and advances them by
// one word per step, producing the result word for that step.
// ----------------------------------------------------------------------------
module owbm_core import owbm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_idx,
  input  logic [CfgW-1:0]    cfg_wdata,
  input  logic               step,
  input  logic [1:0]         kind,
  input  logic [7:0]         tx_byte,
  input  logic               line_level,
  output res_t               res
);

  logic [9:0]       reset_low_r;
  logic [7:0]       presence_wait_r;
  logic [7:0]       slot_r;
  logic [7:0]       sample_delay_r;

  logic [1:0]       phase_r, phase_nxt;
  logic [TickW-1:0] tick_r, tick_nxt;
  logic [2:0]       bit_r, bit_nxt;
  logic [7:0]       sout_r, sout_nxt;
  logic [7:0]       sin_r, sin_nxt;
  logic             pres_r, pres_nxt;

  logic [TickW-1:0] tick_inc;
  logic [9:0]       low_lim;
  logic [7:0]       pw;
  logic [9:0]       rst_end;
  logic [8:0]       slot_end;
  logic [7:0]       sd;
  logic             done;
  logic             rejected;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reset_low_r     <= RESET_LOW_DEF;
      presence_wait_r <= PRESENCE_WAIT_DEF;
      slot_r          <= SLOT_DEF;
      sample_delay_r  <= SAMPLE_DELAY_DEF;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_RESET_LOW:     reset_low_r     <= cfg_wdata;
        CFG_PRESENCE_WAIT: presence_wait_r <= cfg_wdata[7:0];
        CFG_SLOT:          slot_r          <= cfg_wdata[7:0];
        CFG_SAMPLE_DELAY:  sample_delay_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign tick_inc = tick_r + 1'b1;
  assign low_lim  = (reset_low_r == '0) ? 10'd1 : reset_low_r;
  assign pw       = (presence_wait_r == '0) ? 8'd1 : presence_wait_r;
  assign rst_end  = (reset_low_r > {2'b00, pw}) ? reset_low_r : {2'b00, pw};
  assign slot_end = {1'b0, slot_r} + 9'd1;
  assign sd       = (sample_delay_r < slot_r) ? sample_delay_r : slot_r;

  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    bit_nxt   = bit_r;
    sout_nxt  = sout_r;
    sin_nxt   = sin_r;
    pres_nxt  = pres_r;
    done      = 1'b0;
    rejected  = 1'b0;
    if (kind != KIND_TICK) begin
      if (phase_r != PH_IDLE) begin
        rejected = 1'b1;
      end else begin
        phase_nxt = kind;
        tick_nxt  = '0;
        bit_nxt   = '0;
        if (kind == KIND_WRITE) sout_nxt = tx_byte;
        if (kind == KIND_READ) sin_nxt = '0;
      end
    end else if (phase_r != PH_IDLE) begin
      tick_nxt = tick_inc;
      if (phase_r == PH_RESET) begin
        if (bit_r == 3'd0) begin
          if (tick_inc >= low_lim) begin
            bit_nxt  = 3'd1;
            tick_nxt = '0;
          end
        end else begin
          if (tick_inc == {2'b00, pw}) pres_nxt = ~line_level;
          if (tick_inc >= rst_end) begin
            phase_nxt = PH_IDLE;
            bit_nxt   = '0;
            tick_nxt  = '0;
            done      = 1'b1;
          end
        end
      end else begin
        if (phase_r == PH_READ && tick_inc == {2'b00, sd} + 10'd1) begin
          sin_nxt[bit_r] = sin_r[bit_r] | line_level;
        end
        if (tick_inc >= {1'b0, slot_end}) begin
          tick_nxt = '0;
          if (bit_r == 3'd7) begin
            phase_nxt = PH_IDLE;
            bit_nxt   = '0;
            done      = 1'b1;
          end else begin
            bit_nxt = bit_r + 3'd1;
            if (phase_r == PH_WRITE) sout_nxt = {1'b0, sout_r[7:1]};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= '0;
      bit_r   <= '0;
      sout_r  <= '0;
      sin_r   <= '0;
      pres_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      bit_r   <= bit_nxt;
      sout_r  <= sout_nxt;
      sin_r   <= sin_nxt;
      pres_r  <= pres_nxt;
    end
  end

  always_comb begin
    case (phase_nxt)
      PH_RESET: res.drive_low = (bit_nxt == 3'd0);
      PH_WRITE: res.drive_low = (tick_nxt == '0) | ~sout_nxt[0];
      PH_READ:  res.drive_low = (tick_nxt == '0);
      default:  res.drive_low = 1'b0;
    endcase
    res.busy_res = (phase_nxt != PH_IDLE);
    res.done_res = done;
    res.presence = pres_nxt;
    res.rx_byte  = sin_nxt;
    res.rejected = rejected;
  end

endmodule

>>> sv/one_wire_bus_master_top.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master_top: 1-Wire bus master, reset/presence and byte slots
// The master takes one word per cycle while its output buffer is not full:
// either a microsecond tick or a command, and returns one result word per
// input word, registered in the output buffer. The two-word buffer keeps
// input acceptance going while the consumer stalls until it holds two
// results; the sustained rate is one word per cycle while the consumer keeps
// up. The user must write the timing registers through the cfg port only
// while the master is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module one_wire_bus_master_top import owbm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_idx,
  input  logic [CfgW-1:0]    cfg_wdata,
  owbm_cmd_if.sink           in_cmd,
  owbm_res_if.source         out_res
);

  res_t       res_new;
  res_t       buf0_r, buf0_nxt;
  res_t       buf1_r, buf1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;

  assign in_cmd.ready = (cnt_r != 2'd2);
  assign push = in_cmd.valid & in_cmd.ready;
  assign pop  = out_res.valid & out_res.ready;

  owbm_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .step       (push),
    .kind       (in_cmd.kind),
    .tx_byte    (in_cmd.tx_byte),
    .line_level (in_cmd.line_level),
    .res        (res_new)
  );

  always_comb begin
    buf0_nxt = buf0_r;
    buf1_nxt = buf1_r;
    cnt_nxt  = cnt_r;
    if (pop) begin
      buf0_nxt = buf1_r;
      cnt_nxt  = cnt_r - 2'd1;
    end
    if (push) begin
      if (cnt_nxt == 2'd0) buf0_nxt = res_new;
      else buf1_nxt = res_new;
      cnt_nxt = cnt_nxt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf0_r <= buf0_nxt;
    buf1_r <= buf1_nxt;
  end

  assign out_res.valid     = (cnt_r != 2'd0);
  assign out_res.drive_low = buf0_r.drive_low;
  assign out_res.busy_res  = buf0_r.busy_res;
  assign out_res.done_res  = buf0_r.done_res;
  assign out_res.presence  = buf0_r.presence;
  assign out_res.rx_byte   = buf0_r.rx_byte;
  assign out_res.rejected  = buf0_r.rejected;

endmodule
